// File: rtl/ackrto_pkg.sv
// Shared types and constants for the ack RTO and congestion window block.
package ackrto_pkg;

	// session table
	localparam int SESSIONS = 16;
	localparam int SES_W    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

	// field widths
	localparam int WIN_W = 16;
	localparam int CR_W  = 40;
	localparam int RTT_W = 48;
	localparam int TO_W  = 32;

	localparam logic [WIN_W-1:0] WIN_MAX    = '1;
	localparam logic [CR_W-1:0]  CREDIT_MAX = '1;
	localparam logic [TO_W-1:0]  TIMEOUT_RESET = 32'd1000000;

	// divider: dividend bits, divisor bits, bits retired per cycle
	localparam int DIV_W     = 42;
	localparam int DVS_W     = CR_W;
	localparam int REM_W     = DVS_W + 1;
	localparam int DIV_BITS  = 2;
	localparam int DIV_STEPS = DIV_W / DIV_BITS;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	// event codes
	localparam logic OP_ACK  = 1'b0;
	localparam logic OP_LOSS = 1'b1;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_SEGMENT     = 3'd0,
		REG_RTO_FLOOR   = 3'd1,
		REG_RTO_CEIL    = 3'd2,
		REG_THR_FLOOR   = 3'd3,
		REG_LOSS_ADD    = 3'd4,
		REG_START_WIN   = 3'd5,
		REG_START_THR   = 3'd6
	} cfg_reg_t;

	// per-session table entry
	typedef struct packed {
		logic [WIN_W-1:0] win;
		logic [WIN_W-1:0] thr;
		logic [CR_W-1:0]  credit;
		logic [WIN_W-1:0] peer;
	} entry_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_RTO,
		S_DIV1,
		S_CMP,
		S_DIV2,
		S_CAP,
		S_WB
	} state_t;

endpackage

// File: rtl/ackrto_div.sv
// Iterative restoring divider, two quotient bits per cycle.
module ackrto_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [ackrto_pkg::DIV_W-1:0]    dividend,
	input  logic [ackrto_pkg::DVS_W-1:0]    divisor,
	output logic                            busy,
	output logic                            done,
	output logic [ackrto_pkg::DIV_W-1:0]    quotient
);
	import ackrto_pkg::*;

	logic [REM_W-1:0]  rem_q, rem_n, trial;
	logic [DIV_W-1:0]  quo_q, quo_n;
	logic [DVS_W-1:0]  dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q, done_q;

	// two shift-subtract steps
	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		trial = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {rem_n[REM_W-2:0], quo_n[DIV_W-1]};
			quo_n = {quo_n[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_n    = trial - {1'b0, dvs_q};
				quo_n[0] = 1'b1;
			end else begin
				rem_n = trial;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/ack_rto_and_congestion_window.sv
// Top level: session table, shared RTT estimator and congestion window update.
// From the accepting edge a loss runs S_READ, S_RTO and S_WB; an ack below threshold
// also runs S_CAP; an ack on the credit rule adds a pass of the shared divider (S_DIV1, S_CMP),
// and a second (S_DIV2) when the window is re-derived; S_WB waits out any out_ready stall.
// One word in flight at a time; the next is taken the cycle after the result is registered.
// Reset: asynchronous, active low; RTT state clears, timeout goes to 1000000,
// every session reads as start window/threshold until its first event.
module ack_rto_and_congestion_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [3:0]                    session_index,
	input  logic [ackrto_pkg::RTT_W-1:0]  rtt_sample,
	input  logic [ackrto_pkg::WIN_W-1:0]  peer_window,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ackrto_pkg::TO_W-1:0]   timeout_now,
	output logic [ackrto_pkg::WIN_W-1:0]  window_now,
	output logic [ackrto_pkg::WIN_W-1:0]  threshold_now
);
	import ackrto_pkg::*;

	// configuration
	logic [15:0] seg_q, thr_floor_q, loss_add_q, start_win_q, start_thr_q;
	logic [31:0] rto_floor_q, rto_ceil_q;

	// control and estimator state
	state_t               state_q, state_d;
	logic [SESSIONS-1:0]  loaded_q;
	logic [RTT_W-1:0]     srtt_q, var_q;
	logic [TO_W-1:0]      timeout_q;
	logic                 out_valid_q;

	// word under work
	logic                 op_q;
	logic [SES_W-1:0]     idx_q;
	logic [RTT_W-1:0]     rtt_q;
	logic [WIN_W-1:0]     pw_q;
	logic [WIN_W-1:0]     w_q, th_q, peer_q;
	logic [CR_W-1:0]      cr_q;
	logic [31:0]          sq_q;
	logic [32:0]          mul_q;

	// session memory
	entry_t               mem_q [SESSIONS];
	entry_t               rd_s1, ent, wr_ent;
	logic [SES_W-1:0]     rd_addr;

	// output registers
	logic [TO_W-1:0]      to_out_q;
	logic [WIN_W-1:0]     win_out_q, thr_out_q;

	// divider hookup
	logic                 div_start, div_busy, div_done;
	logic [DIV_W-1:0]     div_dividend, div_q;
	logic [DVS_W-1:0]     div_divisor;

	logic                 in_acc, mem_we, out_load;
	logic [15:0]          mtu;
	logic [RTT_W-1:0]     rtt_d, srtt_n, var_n;
	logic [RTT_W+3:0]     srtt_sum;
	logic [RTT_W+2:0]     var_sum, tsum, tclamp;
	logic [WIN_W-1:0]     th_loss;
	logic [WIN_W:0]       w_inc, w_loss;
	logic [CR_W:0]        cr_inc;
	logic [CR_W-1:0]      cr_max;
	logic [CR_W+1:0]      cr_grow;

	assign mtu    = (seg_q == '0) ? 16'd1 : seg_q;
	assign in_acc = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q       <= 16'd4096;
			rto_floor_q <= 32'd1000;
			rto_ceil_q  <= 32'd1000000;
			thr_floor_q <= 16'd2;
			loss_add_q  <= 16'd2;
			start_win_q <= 16'd1;
			start_thr_q <= 16'd32;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SEGMENT:   seg_q       <= cfg_data[15:0];
				REG_RTO_FLOOR: rto_floor_q <= cfg_data;
				REG_RTO_CEIL:  rto_ceil_q  <= cfg_data;
				REG_THR_FLOOR: thr_floor_q <= cfg_data[15:0];
				REG_LOSS_ADD:  loss_add_q  <= cfg_data[15:0];
				REG_START_WIN: start_win_q <= cfg_data[15:0];
				REG_START_THR: start_thr_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// entry as seen by the event: fresh sessions take the start values
	always_comb begin
		if (loaded_q[idx_q]) begin
			ent = rd_s1;
		end else begin
			ent.win    = start_win_q;
			ent.thr    = start_thr_q;
			ent.credit = '0;
			ent.peer   = '0;
		end
	end

	// Jacobson smoothing
	always_comb begin
		rtt_d    = (rtt_q >= srtt_q) ? rtt_q - srtt_q : srtt_q - rtt_q;
		var_sum  = {3'b0, var_q} + {2'b0, var_q, 1'b0} + {3'b0, rtt_d};
		srtt_sum = {1'b0, srtt_q, 3'b0} - {4'b0, srtt_q} + {4'b0, rtt_q};
		if (srtt_q == '0) begin
			srtt_n = rtt_q;
			var_n  = rtt_q >> 1;
		end else begin
			var_n  = var_sum[RTT_W+1:2];
			srtt_n = (srtt_sum[RTT_W+2:3] == '0) ? RTT_W'(1) : srtt_sum[RTT_W+2:3];
		end
	end

	// timeout clamp, ceiling wins
	always_comb begin
		tsum   = {3'b0, srtt_q} + {1'b0, var_q, 2'b0};
		tclamp = tsum;
		if (tclamp < {19'b0, rto_floor_q}) tclamp = {19'b0, rto_floor_q};
		if (tclamp > {19'b0, rto_ceil_q})  tclamp = {19'b0, rto_ceil_q};
	end

	// window arithmetic
	always_comb begin
		th_loss = (w_q >> 1) < thr_floor_q ? thr_floor_q : (w_q >> 1);
		w_loss  = {1'b0, th_loss} + {1'b0, loss_add_q};
		w_inc   = {1'b0, w_q} + 1'b1;
		cr_inc  = {1'b0, cr_q} + {25'b0, mtu};
		cr_max  = (cr_q < {24'b0, mtu}) ? {24'b0, mtu} : cr_q;
		cr_grow = {2'b0, cr_q} + div_q + {26'b0, mtu >> 4};
	end

	// divider operands
	always_comb begin
		if (state_q == S_CMP) begin
			div_dividend = {2'b0, cr_q} + {26'b0, mtu} - 1'b1;
			div_divisor  = {24'b0, mtu};
		end else begin
			div_dividend = {10'b0, sq_q};
			div_divisor  = cr_max;
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		mem_we    = 1'b0;
		out_load  = 1'b0;
		in_ready  = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: if (in_acc) state_d = S_READ;
			S_READ: state_d = S_RTO;
			S_RTO: begin
				if (op_q == OP_LOSS) begin
					state_d = S_WB;
				end else if (w_q < th_q) begin
					state_d = S_CAP;
				end else begin
					div_start = 1'b1;
					state_d   = S_DIV1;
				end
			end
			S_DIV1: if (div_done) state_d = S_CMP;
			S_CMP: begin
				if ({7'b0, mul_q} <= cr_q) begin
					div_start = 1'b1;
					state_d   = S_DIV2;
				end else begin
					state_d = S_CAP;
				end
			end
			S_DIV2: if (div_done) state_d = S_CAP;
			S_CAP:  state_d = S_WB;
			S_WB: begin
				if (!out_valid_q || out_ready) begin
					mem_we   = 1'b1;
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loaded_q    <= '0;
			srtt_q      <= '0;
			var_q       <= '0;
			timeout_q   <= TIMEOUT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_READ && op_q == OP_ACK) begin
				srtt_q <= srtt_n;
				var_q  <= var_n;
			end
			if (state_q == S_RTO && op_q == OP_ACK) timeout_q <= tclamp[TO_W-1:0];
			if (mem_we) loaded_q[idx_q] <= 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					op_q  <= opcode;
					idx_q <= session_index[SES_W-1:0];
					rtt_q <= rtt_sample;
					pw_q  <= peer_window;
				end
			end
			S_READ: begin
				w_q    <= ent.win;
				th_q   <= ent.thr;
				cr_q   <= ent.credit;
				peer_q <= ent.peer;
				sq_q   <= mtu * mtu;
				mul_q  <= ({1'b0, ent.win} + 17'd1) * {1'b0, mtu};
			end
			S_RTO: begin
				if (op_q == OP_LOSS) begin
					th_q <= th_loss;
					w_q  <= w_loss[WIN_W] ? WIN_MAX : w_loss[WIN_W-1:0];
					cr_q <= {24'b0, seg_q};
				end else if (w_q < th_q) begin
					w_q  <= w_inc[WIN_W] ? WIN_MAX : w_inc[WIN_W-1:0];
					cr_q <= cr_inc[CR_W] ? CREDIT_MAX : cr_inc[CR_W-1:0];
				end else begin
					cr_q <= cr_max;
				end
			end
			S_DIV1: begin
				if (div_done) begin
					cr_q <= (cr_grow[CR_W+1:CR_W] != '0) ? CREDIT_MAX : cr_grow[CR_W-1:0];
				end
			end
			S_DIV2: begin
				if (div_done) begin
					w_q <= (div_q[DIV_W-1:WIN_W] != '0) ? WIN_MAX : div_q[WIN_W-1:0];
				end
			end
			S_CAP: begin
				peer_q <= pw_q;
				if (pw_q < w_q) w_q <= pw_q;
			end
			default: ;
		endcase
	end

	// session memory, registered read; the read is issued on the accepting edge
	always_comb begin
		wr_ent.win    = w_q;
		wr_ent.thr    = th_q;
		wr_ent.credit = cr_q;
		wr_ent.peer   = peer_q;
		rd_addr       = in_acc ? session_index[SES_W-1:0] : idx_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[idx_q] <= wr_ent;
		rd_s1 <= mem_q[rd_addr];
	end

	// result word
	always_ff @(posedge clk) begin
		if (out_load) begin
			to_out_q  <= timeout_q;
			win_out_q <= w_q;
			thr_out_q <= th_q;
		end
	end

	ackrto_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign out_valid     = out_valid_q;
	assign timeout_now   = to_out_q;
	assign window_now    = win_out_q;
	assign threshold_now = thr_out_q;

`ifndef SYNTHESIS
	// a loss result never leaves the threshold below its floor
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && op_q == OP_LOSS) |=> (threshold_now >= thr_floor_q))
		else $error("loss threshold below floor");

	// divider runs right after a start
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_busy)
		else $error("divider did not start");

	// no new word while the divider works
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !div_busy)
		else $error("word accepted during division");
`endif

endmodule

// File: sim/ack_rto_and_congestion_window_tb.sv
// Testbench for the ack RTO and congestion window block: directed and random events vs a predictor.
`timescale 1ns / 1ps

module ack_rto_and_congestion_window_tb;
	import ackrto_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = 1'b0;
	logic [3:0] session_index = '0;
	logic [RTT_W-1:0] rtt_sample = '0;
	logic [WIN_W-1:0] peer_window = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [TO_W-1:0] timeout_now;
	logic [WIN_W-1:0] window_now;
	logic [WIN_W-1:0] threshold_now;

	ack_rto_and_congestion_window dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	typedef struct packed {
		logic [TO_W-1:0]  tmo;
		logic [WIN_W-1:0] win;
		logic [WIN_W-1:0] thr;
	} cwnd_result_t;

	cwnd_result_t expected_q[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit timed_out = 0;

	// predictor copy of the configuration
	logic [15:0] p_seg, p_thr_floor, p_loss_add, p_start_win, p_start_thr;
	logic [31:0] p_rto_floor, p_rto_ceil;
	// predictor copy of the state
	logic [47:0] p_srtt, p_rttvar;
	logic [31:0] p_tmo;
	logic [15:0] p_win[SESSIONS];
	logic [15:0] p_thr[SESSIONS];
	logic [39:0] p_credit[SESSIONS];
	bit p_loaded[SESSIONS];

	function automatic logic [15:0] sat_win(logic [63:0] v);
		return (v > 64'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic [39:0] sat_credit(logic [63:0] v);
		return (v > {24'd0, {40{1'b1}}}) ? '1 : v[39:0];
	endfunction

	task automatic predict_reset();
		p_seg = 16'd4096; p_rto_floor = 32'd1000; p_rto_ceil = 32'd1000000;
		p_thr_floor = 16'd2; p_loss_add = 16'd2; p_start_win = 16'd1; p_start_thr = 16'd32;
		p_srtt = '0; p_rttvar = '0; p_tmo = 32'd1000000;
		for (int i = 0; i < SESSIONS; i++) begin
			p_win[i] = '0; p_thr[i] = '0; p_credit[i] = '0; p_loaded[i] = 1'b0;
		end
	endtask

	// Jacobson estimator, shared by all sessions
	function automatic void estimate_rtt(logic [47:0] rtt);
		logic [63:0] d, t;
		if (p_srtt == 0) begin
			p_srtt = rtt;
			p_rttvar = rtt >> 1;
		end else begin
			d = 64'((rtt >= p_srtt) ? rtt - p_srtt : p_srtt - rtt);
			p_rttvar = 48'((64'd3 * p_rttvar + d) >> 2);
			p_srtt = 48'((64'd7 * p_srtt + rtt) >> 3);
			if (p_srtt < 1) p_srtt = 48'd1;
		end
		t = {16'd0, p_srtt} + 64'd4 * p_rttvar;
		if (t < p_rto_floor) t = 64'(p_rto_floor);
		if (t > p_rto_ceil) t = 64'(p_rto_ceil);
		p_tmo = t[31:0];
	endfunction

	function automatic cwnd_result_t predict_window(logic op, logic [3:0] s,
			logic [47:0] rtt, logic [15:0] pw);
		logic [63:0] mtu, w, th, cr;
		cwnd_result_t r;
		mtu = (p_seg != 0) ? 64'(p_seg) : 64'd1;
		if (!p_loaded[s]) begin
			p_loaded[s] = 1'b1;
			p_win[s] = p_start_win;
			p_thr[s] = p_start_thr;
		end
		w = 64'(p_win[s]); th = 64'(p_thr[s]); cr = 64'(p_credit[s]);
		if (op == OP_ACK) begin
			estimate_rtt(rtt);
			if (w < th) begin
				w = 64'(sat_win(w + 64'd1));
				cr = 64'(sat_credit(cr + mtu));
			end else begin
				if (cr < mtu) cr = mtu;
				cr = 64'(sat_credit(cr + (mtu * mtu) / cr + (mtu >> 4)));
				if ((w + 64'd1) * mtu <= cr) w = 64'(sat_win((cr + mtu - 64'd1) / mtu));
			end
			if (pw < w) w = 64'(pw);
		end else begin
			th = w >> 1;
			if (th < p_thr_floor) th = 64'(p_thr_floor);
			w = 64'(sat_win(th + 64'(p_loss_add)));
			cr = 64'(p_seg);
		end
		p_win[s] = w[15:0]; p_thr[s] = th[15:0]; p_credit[s] = cr[39:0];
		r.tmo = p_tmo; r.win = w[15:0]; r.thr = th[15:0];
		return r;
	endfunction

	// send one event word and record its expected result; valid drops only while idling
	task automatic send_event(logic op, logic [3:0] s, logic [47:0] rtt, logic [15:0] pw);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		expected_q = {expected_q, predict_window(op, s, rtt, pw)};
		in_valid <= 1'b1;
		opcode <= op; session_index <= s; rtt_sample <= rtt; peer_window <= pw;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SEGMENT:   p_seg = val[15:0];
			REG_RTO_FLOOR: p_rto_floor = val;
			REG_RTO_CEIL:  p_rto_ceil = val;
			REG_THR_FLOOR: p_thr_floor = val[15:0];
			REG_LOSS_ADD:  p_loss_add = val[15:0];
			REG_START_WIN: p_start_win = val[15:0];
			REG_START_THR: p_start_thr = val[15:0];
			default: ;
		endcase
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// rtt mostly small, sometimes full width
	function automatic logic [47:0] rand_rtt();
		case ($urandom_range(3))
			0: return 48'({$urandom, $urandom});
			1: return 48'($urandom_range(20));
			default: return 48'($urandom_range(200000));
		endcase
	endfunction

	function automatic logic [15:0] rand_peer();
		return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(65535, 60000));
	endfunction

	// result checker
	always @(posedge clk) begin
		cwnd_result_t got, exp_r;
		if (arst_n && out_valid && out_ready) begin
			got = '{timeout_now, window_now, threshold_now};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
			end else begin
				exp_r = expected_q.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp to=%0d w=%0d th=%0d got to=%0d w=%0d th=%0d",
							exp_r.tmo, exp_r.win, exp_r.thr, got.tmo, got.win, got.thr);
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// watchdog on cycles with no accepted word and no result taken
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else if (in_valid || expected_q.size() != 0) idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) timed_out = 1;
	end

	task automatic test_directed_extremes();
		send_event(OP_ACK, 4'd0, 48'd0, 16'hFFFF);          // zero first sample
		send_event(OP_ACK, 4'd0, 48'd100, 16'hFFFF);        // real first sample
		send_event(OP_ACK, 4'd0, 48'hFFFF_FFFF_FFFF, 16'd0);
		send_event(OP_ACK, 4'd0, 48'd1, 16'hFFFF);
		send_event(OP_LOSS, 4'd15, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
		for (int i = 0; i < 6; i++) send_event(OP_ACK, 4'd3, 48'(50 + i), 16'hFFFF);
		send_event(OP_LOSS, 4'd3, 48'd0, 16'd0);
		send_event(OP_ACK, 4'd15, 48'd0, 16'h8000);
		wait_drain();
	endtask

	task automatic test_config_extremes();
		// floor above ceiling, zero segment, large windows
		write_reg(REG_RTO_FLOOR, 32'hFFFF_FFFF);
		write_reg(REG_RTO_CEIL, 32'd5);
		write_reg(REG_SEGMENT, 32'd0);
		write_reg(REG_START_WIN, 32'h0000_FFFF);
		write_reg(REG_START_THR, 32'd0);
		write_reg(REG_THR_FLOOR, 32'h0000_FFFF);
		write_reg(REG_LOSS_ADD, 32'h0000_FFFF);
		send_event(OP_ACK, 4'd7, 48'd300, 16'hFFFF);
		send_event(OP_ACK, 4'd7, 48'd300, 16'hFFFF);
		send_event(OP_LOSS, 4'd7, 48'd0, 16'd0);
		send_event(OP_ACK, 4'd8, 48'd300, 16'hFFFF);
		wait_drain();
		write_reg(REG_SEGMENT, 32'h0000_FFFF);
		write_reg(REG_THR_FLOOR, 32'd0);
		write_reg(REG_LOSS_ADD, 32'd0);
		write_reg(REG_RTO_FLOOR, 32'd1);
		write_reg(REG_RTO_CEIL, 32'hFFFF_FFFF);
		send_event(OP_LOSS, 4'd9, 48'd0, 16'd0);
		send_event(OP_ACK, 4'd9, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
		send_event(OP_ACK, 4'd9, 48'h8000_0000_0000, 16'hFFFF);
		wait_drain();
	endtask

	task automatic test_random(int n, int snd, int rcv);
		send_idle_pct = snd;
		recv_idle_pct = rcv;
		write_reg(REG_SEGMENT, $urandom_range(3) == 0 ? $urandom : $urandom_range(1500, 1));
		write_reg(REG_RTO_FLOOR, $urandom_range(5000));
		write_reg(REG_RTO_CEIL, $urandom_range(1) ? 32'hFFFF_FFFF : $urandom);
		write_reg(REG_THR_FLOOR, $urandom_range(8));
		write_reg(REG_LOSS_ADD, $urandom_range(4));
		write_reg(REG_START_WIN, $urandom_range(40, 1));
		write_reg(REG_START_THR, $urandom_range(64));
		for (int i = 0; i < n; i++)
			send_event(($urandom_range(9) == 0) ? OP_LOSS : OP_ACK, 4'($urandom),
				rand_rtt(), rand_peer());
		wait_drain();
	endtask

	initial begin
		predict_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_config_extremes();
		test_random(500, 15, 46);
		test_random(500, 46, 15);
		test_random(500, 0, 0);
		if (mismatches == 0 && expected_q.size() == 0 && !timed_out) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		wait (timed_out);
		$display("FAILURE");
		$finish;
	end

endmodule
